/* rtl/pev_pkg.sv */
// Package for the pose error velocity block: payload structs, register codes,
// fixed-point widths and the rounding and saturation helpers.
// No dependencies.
package pev_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned MagW    = DataW + 1;          // |goal - cur|
  localparam int unsigned SumW    = 2 * MagW;           // sum of squares
  localparam int unsigned RootW   = SumW / 2;           // floor sqrt
  localparam int unsigned SqrtSteps = SumW / 2;         // one root bit per stage
  localparam int unsigned SqrtRemW  = RootW + 2;
  localparam int unsigned NumW    = MagW + LimitW;      // |d| * speed_limit
  localparam int unsigned DivSteps = RootW;             // quotient bits
  localparam int unsigned ProdW   = 50;                 // rounded Q.16 product
  localparam int unsigned WideW   = 68;                 // exact sums before saturation
  localparam int unsigned MatN    = 9;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_GOAL_PX,
    REG_GOAL_PY,
    REG_GOAL_PZ,
    REG_GOAL_QX,
    REG_GOAL_QY,
    REG_GOAL_QZ,
    REG_GOAL_QW,
    REG_SPEED_LIMIT
  } pev_reg_e;

  localparam logic [DataW-1:0]  GoalQwReset     = 32'h0001_0000;
  localparam logic [LimitW-1:0] SpeedLimitReset = 31'h0001_0000;

  typedef logic signed [DataW-1:0] fix_t;

  typedef struct packed {
    fix_t cur_px;
    fix_t cur_py;
    fix_t cur_pz;
    fix_t cur_qx;
    fix_t cur_qy;
    fix_t cur_qz;
    fix_t cur_qw;
  } pev_in_t;

  typedef struct packed {
    fix_t vel_x;
    fix_t vel_y;
    fix_t vel_z;
    fix_t rot_x;
    fix_t rot_y;
    fix_t rot_z;
  } pev_out_t;

  // Rotation matrix, entry (i,k) at index 3*i+k
  typedef logic [MatN-1:0][DataW-1:0] pev_mat_t;

  // Data that rides along the root and divide pipelines
  typedef struct packed {
    logic [2:0][MagW-1:0]  mag;
    logic [2:0]            neg;
    logic                  lim;
    logic [2:0][DataW-1:0] rot;
  } pev_side_t;

  // Saturate an exact wide value to 32-bit signed
  function automatic logic [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    if (v[WideW-1:DataW-1] == {(WideW-DataW+1){v[WideW-1]}}) begin
      return v[DataW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  // Product rounded to Q.16, half up: floor((a*b + 2^15) / 2^16)
  function automatic logic signed [ProdW-1:0] rmul(input logic signed [MagW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [SumW-1:0] p;
    p = a * b;
    p = p + SumW'(32768);
    return p[SumW-1:16];
  endfunction

  // Sign extension of a rounded product
  function automatic logic signed [WideW-1:0] wide(input logic signed [ProdW-1:0] v);
    return {{(WideW-ProdW){v[ProdW-1]}}, v};
  endfunction

endpackage

/* rtl/pev_quat.sv */
// Quaternion to rotation matrix, two register stages: rounded products, then
// the saturated matrix entries. Uses pev_pkg.
module pev_quat (
  input  logic             clk_i,
  input  logic             en_i,
  input  pev_pkg::fix_t    qx_i,
  input  pev_pkg::fix_t    qy_i,
  input  pev_pkg::fix_t    qz_i,
  input  pev_pkg::fix_t    qw_i,
  output pev_pkg::pev_mat_t mat_o
);

  localparam logic signed [pev_pkg::WideW-1:0] One = pev_pkg::WideW'(65536);

  logic signed [pev_pkg::MagW-1:0] x_e, y_e, z_e, w_e;
  logic signed [pev_pkg::ProdW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  pev_pkg::pev_mat_t mat_d, mat_q;

  assign x_e = {qx_i[pev_pkg::DataW-1], qx_i};
  assign y_e = {qy_i[pev_pkg::DataW-1], qy_i};
  assign z_e = {qz_i[pev_pkg::DataW-1], qz_i};
  assign w_e = {qw_i[pev_pkg::DataW-1], qw_i};

  // Stage A: nine rounded component products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= pev_pkg::rmul(x_e, qx_i);
      yy_q <= pev_pkg::rmul(y_e, qy_i);
      zz_q <= pev_pkg::rmul(z_e, qz_i);
      xy_q <= pev_pkg::rmul(x_e, qy_i);
      xz_q <= pev_pkg::rmul(x_e, qz_i);
      yz_q <= pev_pkg::rmul(y_e, qz_i);
      wx_q <= pev_pkg::rmul(w_e, qx_i);
      wy_q <= pev_pkg::rmul(w_e, qy_i);
      wz_q <= pev_pkg::rmul(w_e, qz_i);
    end
  end

  // Stage B: matrix entries, saturated
  always_comb begin
    mat_d[0] = pev_pkg::sat32(One - ((pev_pkg::wide(yy_q) + pev_pkg::wide(zz_q)) <<< 1));
    mat_d[1] = pev_pkg::sat32((pev_pkg::wide(xy_q) - pev_pkg::wide(wz_q)) <<< 1);
    mat_d[2] = pev_pkg::sat32((pev_pkg::wide(xz_q) + pev_pkg::wide(wy_q)) <<< 1);
    mat_d[3] = pev_pkg::sat32((pev_pkg::wide(xy_q) + pev_pkg::wide(wz_q)) <<< 1);
    mat_d[4] = pev_pkg::sat32(One - ((pev_pkg::wide(xx_q) + pev_pkg::wide(zz_q)) <<< 1));
    mat_d[5] = pev_pkg::sat32((pev_pkg::wide(yz_q) - pev_pkg::wide(wx_q)) <<< 1);
    mat_d[6] = pev_pkg::sat32((pev_pkg::wide(xz_q) - pev_pkg::wide(wy_q)) <<< 1);
    mat_d[7] = pev_pkg::sat32((pev_pkg::wide(yz_q) + pev_pkg::wide(wx_q)) <<< 1);
    mat_d[8] = pev_pkg::sat32(One - ((pev_pkg::wide(xx_q) + pev_pkg::wide(yy_q)) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

/* rtl/pev_sqrt.sv */
// Pipelined floor square root of the squared distance, one root bit per
// stage, with side data carried alongside. Uses pev_pkg.
module pev_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [pev_pkg::SumW-1:0]    sum_i,
  input  pev_pkg::pev_side_t          side_i,
  output logic                        valid_o,
  output logic [pev_pkg::RootW-1:0]   root_o,
  output pev_pkg::pev_side_t          side_o
);

  localparam int unsigned Steps = pev_pkg::SqrtSteps;
  localparam int unsigned RemW  = pev_pkg::SqrtRemW;
  localparam int unsigned CandW = RemW + 2;

  logic                      v_q    [Steps];
  logic [RemW-1:0]           rem_q  [Steps];
  logic [pev_pkg::RootW-1:0] root_q [Steps];
  logic [pev_pkg::SumW-1:0]  sum_q  [Steps];
  pev_pkg::pev_side_t        side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                      v_in;
    logic [RemW-1:0]           rem_in;
    logic [pev_pkg::RootW-1:0] root_in;
    logic [pev_pkg::SumW-1:0]  sum_in;
    pev_pkg::pev_side_t        side_in;
    logic [CandW-1:0]          cand, trial, diff;
    logic                      ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sum_in  = sum_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sum_in  = sum_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two bits, try root*4+1
    always_comb begin
      cand  = {rem_in, sum_in[pev_pkg::SumW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      ge    = (cand >= trial);
      diff  = cand - trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[RemW-1:0] : cand[RemW-1:0];
        root_q[k] <= {root_in[pev_pkg::RootW-2:0], ge};
        sum_q[k]  <= {sum_in[pev_pkg::SumW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

/* rtl/pev_div.sv */
// Pipelined scaling of the three position errors: |d| * speed_limit, then a
// restoring divide by the norm, one quotient bit per stage. Uses pev_pkg.
module pev_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [pev_pkg::RootW-1:0]           norm_i,
  input  logic [pev_pkg::LimitW-1:0]          limit_i,
  input  pev_pkg::pev_side_t                  side_i,
  output logic                                valid_o,
  output logic [2:0][pev_pkg::RootW-1:0]      quo_o,
  output pev_pkg::pev_side_t                  side_o
);

  localparam int unsigned Steps = pev_pkg::DivSteps;
  localparam int unsigned RemW  = pev_pkg::RootW;

  // Multiply stage
  logic                                 mv_q;
  logic [2:0][pev_pkg::NumW-1:0]        num_q;
  logic [pev_pkg::RootW-1:0]            mnorm_q;
  pev_pkg::pev_side_t                   mside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en_i) begin
      mv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        num_q[j] <= pev_pkg::NumW'(side_i.mag[j]) * pev_pkg::NumW'(limit_i);
      end
      mnorm_q <= norm_i;
      mside_q <= side_i;
    end
  end

  // Divide stages; lq shifts out dividend bits and shifts in quotient bits
  logic                          v_q    [Steps];
  logic [2:0][RemW-1:0]          rem_q  [Steps];
  logic [2:0][RemW-1:0]          lq_q   [Steps];
  logic [pev_pkg::RootW-1:0]     norm_q [Steps];
  pev_pkg::pev_side_t            side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                      v_in;
    logic [2:0][RemW-1:0]      rem_in, lq_in, rem_nx, lq_nx;
    logic [pev_pkg::RootW-1:0] norm_in;
    pev_pkg::pev_side_t        side_in;
    logic [RemW:0]             cand, diff;

    if (k == 0) begin : g_first
      assign v_in    = mv_q;
      assign norm_in = mnorm_q;
      assign side_in = mside_q;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = RemW'(num_q[j][pev_pkg::NumW-1:Steps]);
        assign lq_in[j]  = num_q[j][Steps-1:0];
      end
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lq_in   = lq_q[k-1];
      assign norm_in = norm_q[k-1];
      assign side_in = side_q[k-1];
    end

    // One restoring step per lane
    always_comb begin
      cand = '0;
      diff = '0;
      for (int j = 0; j < 3; j++) begin
        cand = {rem_in[j], lq_in[j][RemW-1]};
        diff = cand - {1'b0, norm_in};
        if (cand >= {1'b0, norm_in}) begin
          rem_nx[j] = diff[RemW-1:0];
          lq_nx[j]  = {lq_in[j][RemW-2:0], 1'b1};
        end else begin
          rem_nx[j] = cand[RemW-1:0];
          lq_nx[j]  = {lq_in[j][RemW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        lq_q[k]   <= lq_nx;
        norm_q[k] <= norm_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign quo_o   = lq_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

/* rtl/pose_error_velocity.sv */
// Pose error velocity: limited linear error and rotation error from a pose.
// Registered in 5 front stages, 33 root stages, 34 scale and divide stages and
// an output register; one transaction per cycle while the skid entry is empty,
// set by the one-bit-per-stage root and divide pipelines.
// Reset clears the goal pose to the origin with identity rotation, the speed
// limit to 1.0 and all valid bits. Uses pev_pkg, pev_quat, pev_sqrt, pev_div.
module pose_error_velocity (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transaction
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pev_pkg::pev_in_t              in_data_i,
  // result transaction
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pev_pkg::pev_out_t             out_data_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pev_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [pev_pkg::DataW-1:0]     cfg_data_i
);

  localparam int unsigned DataW = pev_pkg::DataW;
  localparam int unsigned MagW  = pev_pkg::MagW;
  localparam int unsigned SumW  = pev_pkg::SumW;

  // Configuration registers
  pev_pkg::fix_t goal_px_q, goal_py_q, goal_pz_q;
  pev_pkg::fix_t goal_qx_q, goal_qy_q, goal_qz_q, goal_qw_q;
  logic [pev_pkg::LimitW-1:0] limit_q;
  logic [2*pev_pkg::LimitW-1:0] limit_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_px_q <= '0;
      goal_py_q <= '0;
      goal_pz_q <= '0;
      goal_qx_q <= '0;
      goal_qy_q <= '0;
      goal_qz_q <= '0;
      goal_qw_q <= pev_pkg::GoalQwReset;
      limit_q   <= pev_pkg::SpeedLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pev_pkg::pev_reg_e'(cfg_index_i))
        pev_pkg::REG_GOAL_PX:     goal_px_q <= cfg_data_i;
        pev_pkg::REG_GOAL_PY:     goal_py_q <= cfg_data_i;
        pev_pkg::REG_GOAL_PZ:     goal_pz_q <= cfg_data_i;
        pev_pkg::REG_GOAL_QX:     goal_qx_q <= cfg_data_i;
        pev_pkg::REG_GOAL_QY:     goal_qy_q <= cfg_data_i;
        pev_pkg::REG_GOAL_QZ:     goal_qz_q <= cfg_data_i;
        pev_pkg::REG_GOAL_QW:     goal_qw_q <= cfg_data_i;
        pev_pkg::REG_SPEED_LIMIT: limit_q   <= cfg_data_i[pev_pkg::LimitW-1:0];
      endcase
    end
  end

  // Squared limit, follows the register
  always_ff @(posedge clk_i) begin
    limit_sq_q <= (2*pev_pkg::LimitW)'(limit_q) * (2*pev_pkg::LimitW)'(limit_q);
  end

  // Pipeline advances unless the skid stage is holding a result
  logic en;
  logic skid_valid_q, skid_valid_d;
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Goal rotation, recomputed continuously
  pev_pkg::pev_mat_t rg_mat, rc_mat;

  pev_quat u_goal_quat (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .qx_i  (goal_qx_q),
    .qy_i  (goal_qy_q),
    .qz_i  (goal_qz_q),
    .qw_i  (goal_qw_q),
    .mat_o (rg_mat)
  );

  // Current rotation, stages 1 and 2
  pev_quat u_cur_quat (
    .clk_i (clk_i),
    .en_i  (en),
    .qx_i  (in_data_i.cur_qx),
    .qy_i  (in_data_i.cur_qy),
    .qz_i  (in_data_i.cur_qz),
    .qw_i  (in_data_i.cur_qw),
    .mat_o (rc_mat)
  );

  // Front stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [MagW-1:0]               d1_q [3];
  logic [2:0][MagW-1:0]                 mag2_q, mag3_q, mag4_q;
  logic [2:0]                           neg2_q, neg3_q, neg4_q;
  logic [SumW-1:0]                      sq3_q [3];
  logic signed [MagW-1:0]               dm3_q [pev_pkg::MatN];
  pev_pkg::pev_mat_t                    rc3_q;
  logic [SumW-1:0]                      n4_q, n5_q;
  logic signed [pev_pkg::ProdW-1:0]     pr4_q [pev_pkg::MatN];
  pev_pkg::pev_side_t                   side5_d, side5_q;

  pev_pkg::fix_t goal_p [3];
  pev_pkg::fix_t cur_p  [3];
  assign goal_p[0] = goal_px_q;
  assign goal_p[1] = goal_py_q;
  assign goal_p[2] = goal_pz_q;
  assign cur_p[0]  = in_data_i.cur_px;
  assign cur_p[1]  = in_data_i.cur_py;
  assign cur_p[2]  = in_data_i.cur_pz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stages 1 to 3 of the linear path: difference, magnitude, squares;
  // stage 3 also forms D = Rg - Rc
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]   <= {goal_p[i][DataW-1], goal_p[i]} - {cur_p[i][DataW-1], cur_p[i]};
        neg2_q[i] <= d1_q[i][MagW-1];
        mag2_q[i] <= d1_q[i][MagW-1] ? MagW'(-d1_q[i]) : MagW'(d1_q[i]);
        sq3_q[i]  <= SumW'(mag2_q[i]) * SumW'(mag2_q[i]);
      end
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      for (int e = 0; e < pev_pkg::MatN; e++) begin
        dm3_q[e] <= {rg_mat[e][DataW-1], rg_mat[e]} - {rc_mat[e][DataW-1], rc_mat[e]};
      end
      rc3_q <= rc_mat;
    end
  end

  // Stage 4: sum of squares; rounded D(a,k) * Rc(b,k) for S21, S02, S10
  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q   <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr4_q[3*j+k] <= pev_pkg::rmul(dm3_q[3*((j+2)%3)+k], rc3_q[3*((j+1)%3)+k]);
        end
      end
    end
  end

  // Stage 5: limit decision and rotation sums
  always_comb begin
    side5_d.mag = mag4_q;
    side5_d.neg = neg4_q;
    side5_d.lim = (n4_q > SumW'(limit_sq_q));
    for (int j = 0; j < 3; j++) begin
      side5_d.rot[j] = pev_pkg::sat32(pev_pkg::wide(pr4_q[3*j]) +
                                      pev_pkg::wide(pr4_q[3*j+1]) +
                                      pev_pkg::wide(pr4_q[3*j+2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q    <= n4_q;
      side5_q <= side5_d;
    end
  end

  // Norm
  logic                       sq_valid;
  logic [pev_pkg::RootW-1:0]  sq_root;
  pev_pkg::pev_side_t         sq_side;

  pev_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .sum_i   (n5_q),
    .side_i  (side5_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Scale by speed_limit / norm
  logic                              dv_valid;
  logic [2:0][pev_pkg::RootW-1:0]    dv_quo;
  pev_pkg::pev_side_t                dv_side;

  pev_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .norm_i  (sq_root),
    .limit_i (limit_q),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Final result: limited or plain error with sign, saturated
  pev_pkg::pev_out_t fin;
  logic [DataW-1:0]  vel [3];

  always_comb begin
    logic [MagW-1:0]                 val;
    logic signed [pev_pkg::WideW-1:0] sv;
    for (int j = 0; j < 3; j++) begin
      val    = dv_side.lim ? dv_quo[j] : dv_side.mag[j];
      sv     = $signed({{(pev_pkg::WideW-MagW){1'b0}}, val});
      vel[j] = pev_pkg::sat32(dv_side.neg[j] ? -sv : sv);
    end
    fin.vel_x = vel[0];
    fin.vel_y = vel[1];
    fin.vel_z = vel[2];
    fin.rot_x = dv_side.rot[0];
    fin.rot_y = dv_side.rot[1];
    fin.rot_z = dv_side.rot[2];
  end

  // Output register with one skid entry
  logic              out_valid_q, out_valid_d;
  pev_pkg::pev_out_t out_q, skid_q;
  logic              out_take, load_out, load_skid, out_from_skid;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (out_take) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (dv_valid) begin
      if (!out_valid_q || out_take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= fin;
    end else if (out_from_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
